// File: hw/rtl/spi_register_command_queue_defines.svh
// Assertion macros shared by the checker of the SPI register command queue.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef SPI_REGISTER_COMMAND_QUEUE_DEFINES_SVH
`define SPI_REGISTER_COMMAND_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/scq_pkg.sv
// Types and constants of the SPI register command queue.
// Used by every module of the block; depends on nothing.
package scq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int FAULT_BIT   = 10;
  localparam int WORD_W      = 16;
  localparam int DATA_W      = 11;
  localparam int ADDR_W      = 4;
  localparam int FPTR_W      = 2;
  localparam int FIFO_DEPTH  = 1 << FPTR_W;

  localparam logic [1:0] RCNT_DONE = 2'd2;

  typedef enum logic [1:0] {
    OP_ENQ_READ  = 2'd0,
    OP_ENQ_WRITE = 2'd1,
    OP_RX_WORD   = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ENQ_STATUS = 2'd0,
    KIND_TX_WORD    = 2'd1,
    KIND_DONE       = 2'd2
  } kind_t;

  typedef enum logic {
    CLS_ENQ = 1'b0,
    CLS_RX  = 1'b1
  } cls_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TX_CMD,
    ST_TX_DUMMY
  } state_t;

  typedef struct packed {
    cls_t              cls;
    logic [WORD_W-1:0] word;
  } op_item_t;

  typedef struct packed {
    kind_t             kind;
    logic              accepted;
    logic [WORD_W-1:0] tx_word;
    logic [WORD_W-1:0] raw_response;
    logic [DATA_W-1:0] response_data;
    logic [ADDR_W-1:0] done_address;
    logic              done_was_write;
    logic [DATA_W-1:0] status_mirror;
    logic              fault_toggle;
    logic              last;
  } res_t;

endpackage

// File: hw/rtl/scq_ifs.sv
// Valid/ready channel interfaces for the request input and the result output.
// Depends on nothing.
interface scq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  reg_address;
  logic [10:0] write_data;
  logic [15:0] rx_word;

  modport source (output valid, op, reg_address, write_data, rx_word, input ready);
  modport sink (input valid, op, reg_address, write_data, rx_word, output ready);
endinterface

interface scq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        accepted;
  logic [15:0] tx_word;
  logic [15:0] raw_response;
  logic [10:0] response_data;
  logic [3:0]  done_address;
  logic        done_was_write;
  logic [10:0] status_mirror;
  logic        fault_toggle;
  logic        last;

  modport source (
    output valid, kind, accepted, tx_word, raw_response, response_data,
           done_address, done_was_write, status_mirror, fault_toggle, last,
    input  ready
  );
  modport sink (
    input  valid, kind, accepted, tx_word, raw_response, response_data,
           done_address, done_was_write, status_mirror, fault_toggle, last,
    output ready
  );
endinterface

// File: hw/rtl/spi_register_command_queue.sv
// SPI register command queue, top level: front end, operation queue, back end.
// Depends on scq_pkg, scq_ifs, scq_front, scq_fifo and scq_back.
// Read and write requests are stored in an eight-slot ring buffer with one slot
// always kept free, so at most seven requests wait at once; a full buffer is
// reported with accepted low. Input words pass through a four-entry operation
// queue, so the input side keeps accepting while results wait on the output.
// The back end produces one result per cycle through its output register when
// not stalled. An enqueue gives a status result, plus the command and dummy
// words if it starts a transaction; a received word completing a transaction
// gives a done result, plus those two words for a waiting request, if any.
// The status register address may be written only while the block is idle.
module spi_register_command_queue import scq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  scq_in_if.sink            in_ch,
  scq_out_if.source         out_ch
);

  logic     push_valid, push_ready;
  op_item_t push_item;
  logic     pop_valid, pop_ready;
  op_item_t pop_item;

  scq_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  scq_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  scq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule

// File: hw/rtl/scq_front.sv
// Front end: accepts input words and turns them into queued operations.
// Depends on scq_pkg and scq_in_if.
module scq_front import scq_pkg::*; (
  scq_in_if.sink     in_ch,
  output logic       push_valid,
  input  logic       push_ready,
  output op_item_t   push_item
);

  op_t op;

  assign op          = op_t'(in_ch.op);
  assign in_ch.ready = push_ready;

  always_comb begin
    push_valid = 1'b0;
    push_item  = '{cls: CLS_ENQ, word: '0};
    unique case (op)
      OP_ENQ_READ: begin
        push_valid = in_ch.valid;
        push_item  = '{cls: CLS_ENQ,
                       word: {1'b1, in_ch.reg_address, {DATA_W{1'b0}}}};
      end
      OP_ENQ_WRITE: begin
        push_valid = in_ch.valid;
        push_item  = '{cls: CLS_ENQ,
                       word: {1'b0, in_ch.reg_address, in_ch.write_data}};
      end
      OP_RX_WORD: begin
        push_valid = in_ch.valid;
        push_item  = '{cls: CLS_RX, word: in_ch.rx_word};
      end
      OP_NONE: begin
        push_valid = 1'b0;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/scq_fifo.sv
// Short operation queue between the front end and the back end.
// Depends on scq_pkg.
module scq_fifo import scq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  op_item_t push_item,
  output logic     pop_valid,
  input  logic     pop_ready,
  output op_item_t pop_item
);

  op_item_t          mem_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (FPTR_W+1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (FPTR_W+1)'(do_push) - (FPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hw/rtl/scq_back.sv
// Back end: request ring buffer, transaction sequencer and result register.
// Depends on scq_pkg and scq_out_if.
module scq_back import scq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  op_item_t          pop_item,
  scq_out_if.source         out_ch
);

  logic [WORD_W-1:0] store_r [QUEUE_DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  state_t            state_r, state_nxt;
  logic [QIDX_W-1:0] head_r, head_nxt;
  logic [QIDX_W-1:0] tail_r, tail_nxt;
  logic              busy_r, busy_nxt;
  logic [1:0]        rcnt_r, rcnt_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic [DATA_W-1:0] status_r, status_nxt;
  logic [ADDR_W-1:0] sra_r;
  logic              out_valid_r;
  res_t              res_r, res_nxt;

  logic              out_free, emit, we;
  logic [QIDX_W-1:0] head_inc, tail_inc;
  logic [1:0]        cnt_inc;
  logic [DATA_W-1:0] rx_data;
  logic [ADDR_W-1:0] cur_addr;
  logic              cur_write, upd;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign head_inc  = (head_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc  = (tail_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign cnt_inc   = (rcnt_r == RCNT_DONE) ? RCNT_DONE : rcnt_r + 2'd1;
  assign rx_data   = pop_item.word[DATA_W-1:0];
  assign cur_addr  = cur_r[WORD_W-2 -: ADDR_W];
  assign cur_write = !cur_r[WORD_W-1];
  assign upd       = !cur_write && (cur_addr == sra_r);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    busy_nxt   = busy_r;
    rcnt_nxt   = rcnt_r;
    cur_nxt    = cur_r;
    status_nxt = status_r;
    we         = 1'b0;
    pop_ready  = 1'b0;
    emit       = 1'b0;
    res_nxt    = '0;
    res_nxt.kind          = KIND_ENQ_STATUS;
    res_nxt.status_mirror = status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid && out_free) begin
          pop_ready = 1'b1;
          unique case (pop_item.cls)
            CLS_ENQ: begin
              emit         = 1'b1;
              res_nxt.last = 1'b1;
              if (head_inc != tail_r) begin
                we               = 1'b1;
                head_nxt         = head_inc;
                res_nxt.accepted = 1'b1;
                if (!busy_r) begin
                  busy_nxt     = 1'b1;
                  rcnt_nxt     = '0;
                  res_nxt.last = 1'b0;
                  state_nxt    = ST_TX_CMD;
                end
              end
            end
            CLS_RX: begin
              rcnt_nxt = cnt_inc;
              if (cnt_inc == RCNT_DONE && busy_r) begin
                emit                   = 1'b1;
                res_nxt.kind           = KIND_DONE;
                res_nxt.raw_response   = pop_item.word;
                res_nxt.response_data  = rx_data;
                res_nxt.done_address   = cur_addr;
                res_nxt.done_was_write = cur_write;
                res_nxt.fault_toggle   = upd && rx_data[FAULT_BIT];
                res_nxt.status_mirror  = upd ? rx_data : status_r;
                res_nxt.last           = 1'b1;
                status_nxt             = upd ? rx_data : status_r;
                busy_nxt               = 1'b0;
                rcnt_nxt               = '0;
                if (head_r != tail_r) begin
                  busy_nxt     = 1'b1;
                  res_nxt.last = 1'b0;
                  state_nxt    = ST_TX_CMD;
                end
              end
            end
            default: begin
              pop_ready = 1'b1;
            end
          endcase
        end
      end
      ST_TX_CMD: begin
        if (out_free) begin
          emit            = 1'b1;
          res_nxt.kind    = KIND_TX_WORD;
          res_nxt.tx_word = rd_data_r;
          cur_nxt         = rd_data_r;
          tail_nxt        = tail_inc;
          state_nxt       = ST_TX_DUMMY;
        end
      end
      ST_TX_DUMMY: begin
        if (out_free) begin
          emit         = 1'b1;
          res_nxt.kind = KIND_TX_WORD;
          res_nxt.last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      busy_r      <= 1'b0;
      rcnt_r      <= '0;
      cur_r       <= '0;
      status_r    <= '0;
      sra_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      busy_r   <= busy_nxt;
      rcnt_r   <= rcnt_nxt;
      cur_r    <= cur_nxt;
      status_r <= status_nxt;
      if (cfg_we) begin
        sra_r <= cfg_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  // A write to the slot being read is forwarded so a fresh request starts at once.
  always_ff @(posedge clk) begin
    if (we) begin
      store_r[head_r] <= pop_item.word;
    end
    if (we && (head_r == tail_r)) begin
      rd_data_r <= pop_item.word;
    end else begin
      rd_data_r <= store_r[tail_r];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.accepted       = res_r.accepted;
  assign out_ch.tx_word        = res_r.tx_word;
  assign out_ch.raw_response   = res_r.raw_response;
  assign out_ch.response_data  = res_r.response_data;
  assign out_ch.done_address   = res_r.done_address;
  assign out_ch.done_was_write = res_r.done_was_write;
  assign out_ch.status_mirror  = res_r.status_mirror;
  assign out_ch.fault_toggle   = res_r.fault_toggle;
  assign out_ch.last           = res_r.last;

endmodule

// File: hw/rtl/scq_checker.sv
// Port-level checks on the result channel of the SPI register command queue.
// Depends on scq_pkg and spi_register_command_queue_defines.svh; bound to the top.
`include "spi_register_command_queue_defines.svh"

module scq_checker import scq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic        out_accepted,
  input logic [15:0] out_tx_word,
  input logic        out_done_was_write,
  input logic        out_fault_toggle,
  input logic        out_last
);

  `SCQ_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_tx_word) && $stable(out_kind) && $stable(out_last), "Stalled result changed")
  `SCQ_ASSERT_NOW(a_tx_only_on_tx, out_valid && (out_kind != KIND_TX_WORD), out_tx_word == '0, "Transmit word set on a non-transmit result")
  `SCQ_ASSERT_NOW(a_reject_is_last, out_valid && (out_kind == KIND_ENQ_STATUS) && !out_accepted, out_last, "Rejected enqueue followed by more results")
  `SCQ_ASSERT_NOW(a_no_fault_on_write, out_valid && (out_kind == KIND_DONE) && out_done_was_write, !out_fault_toggle, "Fault reported for a write")

endmodule

bind spi_register_command_queue scq_checker u_scq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_kind           (out_ch.kind),
  .out_accepted       (out_ch.accepted),
  .out_tx_word        (out_ch.tx_word),
  .out_done_was_write (out_ch.done_was_write),
  .out_fault_toggle   (out_ch.fault_toggle),
  .out_last           (out_ch.last)
);

// File: verif/spi_register_command_queue_tb.sv
// Self-checking testbench for the SPI register command queue.
// Needs scq_pkg, the scq_in_if and scq_out_if interfaces and the RTL top level.
// A typed directed table is followed by random phases; all results are checked in order.
module spi_register_command_queue_tb;
  import scq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 11;
  localparam int IDLE_PERCENT    = 22;
  localparam int ITEMS_PER_PHASE = 24;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int STALL_LIMIT     = 3000;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [WORD_W-1:0] rx;
    bit                typed;
    res_t              want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  scq_in_if  in_ch ();
  scq_out_if out_ch ();

  spi_register_command_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic [WORD_W-1:0] req_slots [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_ptr = '0;
  logic [QIDX_W-1:0] rd_ptr = '0;
  logic              xfer_busy = 1'b0;
  logic [1:0]        rx_seen = '0;
  logic [WORD_W-1:0] cur_cmd = '0;
  logic [DATA_W-1:0] status_shadow = '0;
  logic [ADDR_W-1:0] status_addr = '0;

  res_t step_results[$];
  res_t expected_results[$];

  bit no_idle = 1'b0;
  bit hold_request = 1'b0;
  int mismatch_count = 0;
  int results_checked = 0;
  int words_sent = 0;
  int full_rejects = 0;
  int status_reads = 0;
  int fault_reads = 0;

  function automatic res_t blank_result(kind_t k);
    res_t r;
    r = '0;
    r.kind = k;
    r.status_mirror = status_shadow;
    return r;
  endfunction

  function automatic string fmt_result(res_t r);
    return $sformatf({"kind=%0d acc=%0d tx=%h raw=%h data=%h addr=%h wr=%0d ",
                      "mirror=%h fault=%0d last=%0d"},
                     r.kind, r.accepted, r.tx_word, r.raw_response, r.response_data,
                     r.done_address, r.done_was_write, r.status_mirror, r.fault_toggle,
                     r.last);
  endfunction

  function automatic stim_row_t row(op_t o, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
                                    logic [WORD_W-1:0] w, bit t = 1'b0, res_t f = '0);
    stim_row_t s;
    s.op = o;
    s.addr = a;
    s.data = d;
    s.rx = w;
    s.typed = t;
    s.want = f;
    return s;
  endfunction

  task automatic launch_next();
    res_t r;
    if (xfer_busy || wr_ptr == rd_ptr) return;
    cur_cmd = req_slots[rd_ptr];
    rd_ptr = rd_ptr + 1'b1;
    xfer_busy = 1'b1;
    rx_seen = '0;
    r = blank_result(KIND_TX_WORD);
    r.tx_word = cur_cmd;
    step_results.push_back(r);
    step_results.push_back(blank_result(KIND_TX_WORD));
  endtask

  task automatic predict_results(op_t o, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
                                 logic [WORD_W-1:0] w);
    res_t              r;
    logic [QIDX_W-1:0] nxt;
    logic [DATA_W-1:0] dat;
    logic [ADDR_W-1:0] caddr;
    logic              wr;
    logic              flt;
    step_results.delete();
    case (o)
      OP_ENQ_READ, OP_ENQ_WRITE: begin
        nxt = wr_ptr + 1'b1;
        r = blank_result(KIND_ENQ_STATUS);
        if (nxt != rd_ptr) begin
          req_slots[wr_ptr] = {o == OP_ENQ_READ, a,
                               (o == OP_ENQ_READ) ? {DATA_W{1'b0}} : d};
          wr_ptr = nxt;
          r.accepted = 1'b1;
          step_results.push_back(r);
          launch_next();
        end else begin
          full_rejects++;
          step_results.push_back(r);
        end
      end
      OP_RX_WORD: begin
        if (rx_seen < RCNT_DONE) rx_seen = rx_seen + 1'b1;
        if (rx_seen >= RCNT_DONE && xfer_busy) begin
          dat = w[DATA_W-1:0];
          caddr = cur_cmd[14:11];
          wr = !cur_cmd[15];
          flt = 1'b0;
          if (!wr && caddr == status_addr) begin
            status_shadow = dat;
            flt = dat[FAULT_BIT];
            status_reads++;
            if (flt) fault_reads++;
          end
          r = blank_result(KIND_DONE);
          r.raw_response = w;
          r.response_data = dat;
          r.done_address = caddr;
          r.done_was_write = wr;
          r.fault_toggle = flt;
          step_results.push_back(r);
          xfer_busy = 1'b0;
          rx_seen = '0;
          launch_next();
        end
      end
      default: ;
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endtask

  task automatic send_word(op_t o, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
                           logic [WORD_W-1:0] w, bit typed = 1'b0, res_t want = '0);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= o;
    in_ch.reg_address <= a;
    in_ch.write_data <= d;
    in_ch.rx_word <= w;
    do @(posedge clk); while (!in_ch.ready);
    predict_results(o, a, d, w);
    if (typed) step_results[0] = want;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
    if (o != OP_NONE) words_sent++;
  endtask

  task automatic write_status_address(logic [ADDR_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    status_addr = v;
  endtask

  task automatic settle();
    while (xfer_busy || wr_ptr != rd_ptr)
      send_word(OP_RX_WORD, ADDR_W'($urandom), DATA_W'($urandom), WORD_W'($urandom));
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind = kind_t'(out_ch.kind);
      got.accepted = out_ch.accepted;
      got.tx_word = out_ch.tx_word;
      got.raw_response = out_ch.raw_response;
      got.response_data = out_ch.response_data;
      got.done_address = out_ch.done_address;
      got.done_was_write = out_ch.done_was_write;
      got.status_mirror = out_ch.status_mirror;
      got.fault_toggle = out_ch.fault_toggle;
      got.last = out_ch.last;
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: %s", fmt_result(got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result %0d mismatch, expected: %s", results_checked, fmt_result(want));
            $display("result %0d mismatch, actual:   %s", results_checked, fmt_result(got));
          end
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    wait (rst_n === 1'b1);
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stuck = 0;
      else stuck++;
    end
    $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    stim_row_t         directed_rows[$];
    logic [ADDR_W-1:0] phase_addr[4];
    logic [ADDR_W-1:0] a;
    op_t               o;
    int                pick;
    int                sent;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_NONE;
    in_ch.reg_address <= '0;
    in_ch.write_data <= '0;
    in_ch.rx_word <= '0;

    directed_rows.push_back(row(OP_RX_WORD, 4'd0, 11'd0, 16'hFFFF));
    directed_rows.push_back(row(OP_NONE, 4'hF, 11'h7FF, 16'hFFFF));
    directed_rows.push_back(row(OP_ENQ_READ, 4'd0, 11'h7FF, 16'h0, 1'b1,
      res_t'{KIND_ENQ_STATUS, 1'b1, 16'h0, 16'h0, 11'h0, 4'h0, 1'b0, 11'h0, 1'b0, 1'b0}));
    directed_rows.push_back(row(OP_ENQ_WRITE, 4'hF, 11'h7FF, 16'h0, 1'b1,
      res_t'{KIND_ENQ_STATUS, 1'b1, 16'h0, 16'h0, 11'h0, 4'h0, 1'b0, 11'h0, 1'b0, 1'b1}));
    directed_rows.push_back(row(OP_RX_WORD, 4'd0, 11'd0, 16'h0000));
    directed_rows.push_back(row(OP_RX_WORD, 4'd0, 11'd0, 16'hFFFF, 1'b1,
      res_t'{KIND_DONE, 1'b0, 16'h0, 16'hFFFF, 11'h7FF, 4'h0, 1'b0, 11'h7FF, 1'b1, 1'b0}));
    directed_rows.push_back(row(OP_RX_WORD, 4'd0, 11'd0, 16'h1234));
    directed_rows.push_back(row(OP_RX_WORD, 4'd0, 11'd0, 16'hA5A5));
    directed_rows.push_back(row(OP_ENQ_READ, 4'd0, 11'd0, 16'h0));
    directed_rows.push_back(row(OP_ENQ_READ, 4'hF, 11'h2AA, 16'h0));
    directed_rows.push_back(row(OP_ENQ_WRITE, 4'd0, 11'h000, 16'h0));
    directed_rows.push_back(row(OP_ENQ_WRITE, 4'd8, 11'h400, 16'h0));
    directed_rows.push_back(row(OP_ENQ_READ, 4'd0, 11'h555, 16'h0));
    directed_rows.push_back(row(OP_ENQ_WRITE, 4'd7, 11'h2AA, 16'h0));
    directed_rows.push_back(row(OP_ENQ_WRITE, 4'd1, 11'h555, 16'h0));
    directed_rows.push_back(row(OP_ENQ_READ, 4'd0, 11'h000, 16'h0));
    directed_rows.push_back(row(OP_ENQ_WRITE, 4'd3, 11'h001, 16'h0, 1'b1,
      res_t'{KIND_ENQ_STATUS, 1'b0, 16'h0, 16'h0, 11'h0, 4'h0, 1'b0, 11'h7FF, 1'b0, 1'b1}));
    directed_rows.push_back(row(OP_ENQ_READ, 4'd2, 11'h000, 16'h0));
    directed_rows.push_back(row(OP_RX_WORD, 4'd0, 11'd0, 16'h0000));
    directed_rows.push_back(row(OP_RX_WORD, 4'd0, 11'd0, 16'h0000, 1'b1,
      res_t'{KIND_DONE, 1'b0, 16'h0, 16'h0, 11'h0, 4'h0, 1'b0, 11'h0, 1'b0, 1'b0}));
    directed_rows.push_back(row(OP_RX_WORD, 4'd0, 11'd0, 16'h0400));
    directed_rows.push_back(row(OP_RX_WORD, 4'd0, 11'd0, 16'h7C00));
    directed_rows.push_back(row(OP_NONE, 4'd0, 11'd0, 16'h0000));

    phase_addr[0] = 4'hF;
    phase_addr[1] = 4'h0;
    phase_addr[2] = ADDR_W'($urandom);
    phase_addr[3] = 4'h9;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_status_address(4'h0);

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
    settle();

    for (int p = 0; p < 4; p++) begin
      write_status_address(phase_addr[p]);
      no_idle = (p == 2);
      if (p == 1) hold_request = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        a = ($urandom_range(0, 99) < 40) ? status_addr : ADDR_W'($urandom);
        if (pick < 3) o = OP_NONE;
        else if (pick < 45) o = $urandom_range(0, 1) ? OP_ENQ_READ : OP_ENQ_WRITE;
        else o = OP_RX_WORD;
        send_word(o, a, DATA_W'($urandom), WORD_W'($urandom));
        if (o != OP_NONE) sent++;
      end
      no_idle = 1'b0;
      settle();
    end

    mismatch_count += expected_results.size();
    $display("Run covered %0d request and SPI words, %0d results checked.",
             words_sent, results_checked);
    $display("Saw %0d full-queue rejections and %0d status reads, %0d with the fault bit.",
             full_rejects, status_reads, fault_reads);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/scq_pkg.sv
hw/rtl/scq_ifs.sv
hw/rtl/scq_front.sv
hw/rtl/scq_fifo.sv
hw/rtl/scq_back.sv
hw/rtl/spi_register_command_queue.sv
hw/rtl/scq_checker.sv
verif/spi_register_command_queue_tb.sv
